// File: hdl/assert_macros.svh
// Assertion macros shared by the CoAP option parser RTL.
// The including module must declare clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define COAPMP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define COAPMP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/coapmp_pkg.sv
// Types, codes and the option number table for the CoAP option parser.
// No dependencies; used by coap_message_option_parser.
package coapmp_pkg;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 4;

	localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_VERSION = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_TOKEN_LENGTH = 1'd1;

	localparam logic [1:0] EXPECTED_VERSION_RST = 2'd1;
	localparam logic [3:0] MAX_TOKEN_LENGTH_RST = 4'd8;

	// byte_kind codes
	localparam logic [2:0] KIND_HEADER  = 3'd0;
	localparam logic [2:0] KIND_TOKEN   = 3'd1;
	localparam logic [2:0] KIND_OPTION  = 3'd2;
	localparam logic [2:0] KIND_VALUE   = 3'd3;
	localparam logic [2:0] KIND_MARKER  = 3'd4;
	localparam logic [2:0] KIND_PAYLOAD = 3'd5;

	// status codes
	localparam logic [2:0] ST_OK            = 3'd0;
	localparam logic [2:0] ST_SHORT         = 3'd1;
	localparam logic [2:0] ST_VERSION       = 3'd2;
	localparam logic [2:0] ST_TOKEN         = 3'd3;
	localparam logic [2:0] ST_NIBBLE15      = 3'd4;
	localparam logic [2:0] ST_TRUNCATED     = 3'd5;
	localparam logic [2:0] ST_BAD_NUMBER    = 3'd6;
	localparam logic [2:0] ST_EMPTY_PAYLOAD = 3'd7;

	localparam logic [7:0]  PAYLOAD_MARKER = 8'hFF;
	localparam logic [3:0]  NIBBLE_EXT1    = 4'd13;
	localparam logic [3:0]  NIBBLE_EXT2    = 4'd14;
	localparam logic [3:0]  NIBBLE_BAD     = 4'd15;
	localparam logic [15:0] EXT1_OFFSET    = 16'd13;
	localparam logic [15:0] EXT2_OFFSET    = 16'd269;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_message;
	} item_t;

	typedef struct packed {
		logic [2:0]  byte_kind;
		logic [7:0]  echo_byte;
		logic [15:0] option_number;
		logic [15:0] option_length;
		logic [1:0]  msg_type;
		logic [3:0]  token_length;
		logic [7:0]  code;
		logic [15:0] message_id;
		logic        message_done;
		logic [2:0]  status;
	} result_t;

	// Option numbers of the base protocol plus the reserved ones.
	function automatic logic number_known(input logic [15:0] n);
		logic known;
		case (n) inside
			16'd0, 16'd1, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7, 16'd8,
			16'd11, 16'd12, 16'd14, 16'd15, 16'd17, 16'd20, 16'd23,
			16'd27, 16'd28, 16'd35, 16'd39, 16'd60,
			16'd128, 16'd132, 16'd136, 16'd140: known = 1'b1;
			default: known = 1'b0;
		endcase
		return known;
	endfunction

endpackage

// File: hdl/coap_message_option_parser.sv
// CoAP message and option parser, one datagram byte per word.
// Depends on coapmp_pkg and assert_macros.svh.
//
// Usage: feed the datagram on item (data_byte, end_of_message) with
// item_valid; a word moves when item_valid is high and item_stall low.
// Every byte gives one result word on result/result_valid, taken when
// result_stall is low: its classification, the option number and length
// decoded so far, the header fields captured so far and the first error.
// The word flagged end_of_message carries message_done and the final
// status, and the parser then starts over for the next datagram.
// The result is registered and valid in the cycle after accept; throughput is
// one byte per cycle when not stalled, set by the single result register.
// While the receiver stalls, the result register holds and item_stall
// rises as soon as the register is full, so no word is lost.
// Reset clears all parse state and loads expected_version 1 and
// max_token_length 8. Write cfg_data to register cfg_index with
// cfg_write only while no message is in flight.
`include "assert_macros.svh"

module coap_message_option_parser (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  coapmp_pkg::item_t                   item,
	output logic                                result_valid,
	input  logic                                result_stall,
	output coapmp_pkg::result_t                 result,
	input  logic                                cfg_write,
	input  logic [coapmp_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [coapmp_pkg::CFG_DATA_W-1:0]   cfg_data
);

	typedef enum logic [2:0] {
		PH_HEADER, PH_TOKEN, PH_OPT_HEAD, PH_DELTA_EXT,
		PH_LEN_EXT, PH_VALUE, PH_PAYLOAD, PH_DISCARD
	} phase_t;

	logic [1:0] exp_ver_q;
	logic [3:0] max_tok_q;

	phase_t      phase_q, phase_d;
	logic [1:0]  hdr_cnt_q, hdr_cnt_d;
	logic [3:0]  tok_left_q, tok_left_d;
	logic [1:0]  ext_left_q, ext_left_d;
	logic [7:0]  ext_first_q, ext_first_d;
	logic [3:0]  dnib_q, dnib_d;
	logic [3:0]  lnib_q, lnib_d;
	logic [15:0] num_q, num_d;
	logic [15:0] len_q, len_d;
	logic [15:0] val_left_q, val_left_d;
	logic [2:0]  err_q, err_d;
	logic [1:0]  ver_q, ver_d;
	logic [1:0]  type_q, type_d;
	logic [3:0]  tlen_q, tlen_d;
	logic [7:0]  code_q, code_d;
	logic [15:0] id_q, id_d;

	logic                result_valid_q;
	coapmp_pkg::result_t result_q;
	logic                item_acc;

	logic [7:0]  b;
	logic        eom;
	logic [2:0]  kind;
	logic [3:0]  dn, ln;
	logic [15:0] ext_val;
	logic [3:0]  ext_nib;
	logic        head_done;   // delta and length fully decoded this byte

	assign item_stall   = result_valid_q & result_stall;
	assign item_acc     = item_valid & ~item_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign b   = item.data_byte;
	assign eom = item.end_of_message;
	assign dn  = b[7:4];
	assign ln  = b[3:0];

	// Extension value for whichever nibble is being extended.
	assign ext_nib = (phase_q == PH_DELTA_EXT) ? dnib_q : lnib_q;
	always_comb begin
		if (ext_nib == coapmp_pkg::NIBBLE_EXT1) begin
			ext_val = {8'd0, b} + coapmp_pkg::EXT1_OFFSET;
		end else begin
			ext_val = {ext_first_q, b} + coapmp_pkg::EXT2_OFFSET;
		end
	end

	always_comb begin
		phase_d     = phase_q;
		hdr_cnt_d   = hdr_cnt_q;
		tok_left_d  = tok_left_q;
		ext_left_d  = ext_left_q;
		ext_first_d = ext_first_q;
		dnib_d      = dnib_q;
		lnib_d      = lnib_q;
		num_d       = num_q;
		len_d       = len_q;
		val_left_d  = val_left_q;
		err_d       = err_q;
		ver_d       = ver_q;
		type_d      = type_q;
		tlen_d      = tlen_q;
		code_d      = code_q;
		id_d        = id_q;
		kind        = coapmp_pkg::KIND_PAYLOAD;
		head_done   = 1'b0;

		unique case (phase_q) inside
			PH_HEADER: begin
				kind = coapmp_pkg::KIND_HEADER;
				unique case (hdr_cnt_q)
					2'd0: begin
						ver_d  = b[7:6];
						type_d = b[5:4];
						tlen_d = b[3:0];
					end
					2'd1: code_d = b;
					2'd2: id_d = {b, 8'd0};
					2'd3: id_d = {id_q[15:8], b};
				endcase
				if (hdr_cnt_q != 2'd3) begin
					hdr_cnt_d = hdr_cnt_q + 2'd1;
				end else if (ver_q != exp_ver_q) begin
					err_d   = coapmp_pkg::ST_VERSION;
					phase_d = PH_DISCARD;
				end else if (tlen_q > max_tok_q) begin
					err_d   = coapmp_pkg::ST_TOKEN;
					phase_d = PH_DISCARD;
				end else if (tlen_q != 4'd0) begin
					tok_left_d = tlen_q;
					phase_d    = PH_TOKEN;
				end else begin
					phase_d = PH_OPT_HEAD;
				end
			end
			PH_TOKEN: begin
				kind       = coapmp_pkg::KIND_TOKEN;
				tok_left_d = tok_left_q - 4'd1;
				if (tok_left_q == 4'd1) begin
					phase_d = PH_OPT_HEAD;
				end
			end
			PH_OPT_HEAD: begin
				if (b == coapmp_pkg::PAYLOAD_MARKER) begin
					kind    = coapmp_pkg::KIND_MARKER;
					phase_d = PH_PAYLOAD;
				end else begin
					kind = coapmp_pkg::KIND_OPTION;
					if (dn == coapmp_pkg::NIBBLE_BAD || ln == coapmp_pkg::NIBBLE_BAD) begin
						err_d   = coapmp_pkg::ST_NIBBLE15;
						phase_d = PH_DISCARD;
					end else begin
						dnib_d = dn;
						lnib_d = ln;
						len_d  = (ln < coapmp_pkg::NIBBLE_EXT1) ? {12'd0, ln} : 16'd0;
						if (dn >= coapmp_pkg::NIBBLE_EXT1) begin
							phase_d    = PH_DELTA_EXT;
							ext_left_d = (dn == coapmp_pkg::NIBBLE_EXT1) ? 2'd1 : 2'd2;
						end else begin
							num_d = num_q + {12'd0, dn};
							if (ln >= coapmp_pkg::NIBBLE_EXT1) begin
								phase_d    = PH_LEN_EXT;
								ext_left_d = (ln == coapmp_pkg::NIBBLE_EXT1) ? 2'd1 : 2'd2;
							end else begin
								head_done = 1'b1;
							end
						end
					end
				end
			end
			PH_DELTA_EXT: begin
				kind = coapmp_pkg::KIND_OPTION;
				if (ext_left_q == 2'd2) begin
					ext_first_d = b;
					ext_left_d  = 2'd1;
				end else begin
					num_d      = num_q + ext_val;
					ext_left_d = 2'd0;
					if (lnib_q >= coapmp_pkg::NIBBLE_EXT1) begin
						phase_d    = PH_LEN_EXT;
						ext_left_d = (lnib_q == coapmp_pkg::NIBBLE_EXT1) ? 2'd1 : 2'd2;
					end else begin
						head_done = 1'b1;
					end
				end
			end
			PH_LEN_EXT: begin
				kind = coapmp_pkg::KIND_OPTION;
				if (ext_left_q == 2'd2) begin
					ext_first_d = b;
					ext_left_d  = 2'd1;
				end else begin
					len_d      = ext_val;
					ext_left_d = 2'd0;
					head_done  = 1'b1;
				end
			end
			PH_VALUE: begin
				kind       = coapmp_pkg::KIND_VALUE;
				val_left_d = val_left_q - 16'd1;
				if (val_left_q == 16'd1) begin
					phase_d = PH_OPT_HEAD;
				end
			end
			PH_PAYLOAD, PH_DISCARD: begin
				kind = coapmp_pkg::KIND_PAYLOAD;
			end
		endcase

		// Option head complete: check the number, then expect the value.
		if (head_done) begin
			if (!coapmp_pkg::number_known(num_d)) begin
				err_d   = coapmp_pkg::ST_BAD_NUMBER;
				phase_d = PH_DISCARD;
			end else begin
				val_left_d = len_d;
				phase_d    = (len_d != 16'd0) ? PH_VALUE : PH_OPT_HEAD;
			end
		end

		// A raised error only lands when none is held yet.
		if (err_q != coapmp_pkg::ST_OK) begin
			err_d = err_q;
		end

		if (eom && err_d == coapmp_pkg::ST_OK) begin
			if (phase_d == PH_HEADER) begin
				err_d = coapmp_pkg::ST_SHORT;
			end else if (phase_d == PH_TOKEN || phase_d == PH_DELTA_EXT ||
				     phase_d == PH_LEN_EXT || phase_d == PH_VALUE) begin
				err_d = coapmp_pkg::ST_TRUNCATED;
			end else if (phase_d == PH_PAYLOAD && kind == coapmp_pkg::KIND_MARKER) begin
				err_d = coapmp_pkg::ST_EMPTY_PAYLOAD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_ver_q <= coapmp_pkg::EXPECTED_VERSION_RST;
			max_tok_q <= coapmp_pkg::MAX_TOKEN_LENGTH_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				coapmp_pkg::REG_EXPECTED_VERSION: exp_ver_q <= cfg_data[1:0];
				coapmp_pkg::REG_MAX_TOKEN_LENGTH: max_tok_q <= cfg_data[3:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			hdr_cnt_q   <= '0;
			tok_left_q  <= '0;
			ext_left_q  <= '0;
			ext_first_q <= '0;
			dnib_q      <= '0;
			lnib_q      <= '0;
			num_q       <= '0;
			len_q       <= '0;
			val_left_q  <= '0;
			err_q       <= coapmp_pkg::ST_OK;
			ver_q       <= '0;
			type_q      <= '0;
			tlen_q      <= '0;
			code_q      <= '0;
			id_q        <= '0;
		end else if (item_acc) begin
			if (eom) begin
				// end of datagram: start over
				phase_q     <= PH_HEADER;
				hdr_cnt_q   <= '0;
				tok_left_q  <= '0;
				ext_left_q  <= '0;
				ext_first_q <= '0;
				dnib_q      <= '0;
				lnib_q      <= '0;
				num_q       <= '0;
				len_q       <= '0;
				val_left_q  <= '0;
				err_q       <= coapmp_pkg::ST_OK;
				ver_q       <= '0;
				type_q      <= '0;
				tlen_q      <= '0;
				code_q      <= '0;
				id_q        <= '0;
			end else begin
				phase_q     <= phase_d;
				hdr_cnt_q   <= hdr_cnt_d;
				tok_left_q  <= tok_left_d;
				ext_left_q  <= ext_left_d;
				ext_first_q <= ext_first_d;
				dnib_q      <= dnib_d;
				lnib_q      <= lnib_d;
				num_q       <= num_d;
				len_q       <= len_d;
				val_left_q  <= val_left_d;
				err_q       <= err_d;
				ver_q       <= ver_d;
				type_q      <= type_d;
				tlen_q      <= tlen_d;
				code_q      <= code_d;
				id_q        <= id_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (item_acc) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			result_q.byte_kind     <= kind;
			result_q.echo_byte     <= b;
			result_q.option_number <= num_d;
			result_q.option_length <= len_d;
			result_q.msg_type      <= type_d;
			result_q.token_length  <= tlen_d;
			result_q.code          <= code_d;
			result_q.message_id    <= id_d;
			result_q.message_done  <= eom;
			result_q.status        <= err_d;
		end
	end

	`COAPMP_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !result_valid_q && phase_q == PH_HEADER, "parser not idle in reset")
	`COAPMP_ASSERT(a_eom_restart, item_acc && eom |=> phase_q == PH_HEADER && hdr_cnt_q == 2'd0 && err_q == coapmp_pkg::ST_OK, "parser did not restart after final byte")
	`COAPMP_ASSERT(a_error_discards, err_q != coapmp_pkg::ST_OK |-> phase_q == PH_DISCARD, "error held outside discard phase")
	`COAPMP_ASSERT(a_result_echo, item_acc |=> result_valid_q && result_q.echo_byte == $past(b), "result word does not match accepted byte")

endmodule

// File: dv/tb_coap_message_option_parser.sv
// Self-checking testbench for coap_message_option_parser: a directed table of datagrams,
// then random framed messages under several register settings, all checked by a predictor.
// Depends on coapmp_pkg and the parser RTL only.
module tb_coap_message_option_parser;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int LONG_HOLD = 120;
	localparam int ITEMS_PER_SETTING = 100;

	typedef enum logic [2:0] {
		P_HEADER, P_TOKEN, P_OPT_HEAD, P_DELTA_EXT, P_LEN_EXT, P_VALUE, P_BODY, P_DISCARD
	} parse_phase_t;

	typedef struct packed {
		logic       on;
		logic [2:0] kind;
		logic [2:0] status;
	} pin_t;

	typedef struct packed {
		coapmp_pkg::result_t word;
		pin_t                pin;
	} due_t;

	typedef struct packed {
		logic [7:0] b;
		logic       eom;
		pin_t       pin;
	} dir_row_t;

	localparam pin_t NO_PIN = '0;

	logic clk = 1'b0;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	coapmp_pkg::item_t item;
	pin_t item_pin;
	logic result_valid;
	logic result_stall;
	coapmp_pkg::result_t result;
	logic cfg_write;
	logic [coapmp_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [coapmp_pkg::CFG_DATA_W-1:0] cfg_data;

	// register copies and per-message parse state
	logic [1:0] cur_ver = coapmp_pkg::EXPECTED_VERSION_RST;
	logic [3:0] cur_max_tok = coapmp_pkg::MAX_TOKEN_LENGTH_RST;
	parse_phase_t ph_now = P_HEADER;
	logic [1:0] hdr_seen = '0;
	logic [3:0] tok_left = '0;
	logic [1:0] ext_cnt = '0;
	logic [7:0] ext_hi = '0;
	logic [3:0] d_nib = '0;
	logic [3:0] l_nib = '0;
	logic [15:0] opt_num = '0;
	logic [15:0] opt_len = '0;
	logic [15:0] val_left = '0;
	logic [2:0] err_now = coapmp_pkg::ST_OK;
	logic [1:0] hdr_ver = '0;
	logic [1:0] hdr_type = '0;
	logic [3:0] hdr_tkl = '0;
	logic [7:0] hdr_code = '0;
	logic [15:0] hdr_id = '0;

	int unsigned known_opts [24] = '{0, 1, 3, 4, 5, 6, 7, 8, 11, 12, 14, 15, 17, 20, 23,
		27, 28, 35, 39, 60, 128, 132, 136, 140};

	due_t reports_due [$];
	logic [7:0] frame [$];
	dir_row_t dir_rows [$];
	int errors = 0;
	int words_out = 0;
	int idle_cycles = 0;
	bit quiet = 1'b0;
	bit long_hold_done = 1'b0;

	coap_message_option_parser DUT (
		.clk,
		.arst_n,
		.item_valid,
		.item_stall,
		.item,
		.result_valid,
		.result_stall,
		.result,
		.cfg_write,
		.cfg_index,
		.cfg_data
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic option_listed(input logic [15:0] n);
		foreach (known_opts[j]) begin
			if (32'(n) == known_opts[j])
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic [15:0] ext_sum(input logic [3:0] nib, input logic [7:0] lo);
		if (nib == coapmp_pkg::NIBBLE_EXT1)
			return {8'h00, lo} + coapmp_pkg::EXT1_OFFSET;
		return {ext_hi, lo} + coapmp_pkg::EXT2_OFFSET;
	endfunction

	// keep the first error, drop the rest of the datagram
	function automatic void abandon(input logic [2:0] code);
		if (err_now == coapmp_pkg::ST_OK)
			err_now = code;
		ph_now = P_DISCARD;
	endfunction

	function automatic void head_done();
		if (!option_listed(opt_num)) begin
			abandon(coapmp_pkg::ST_BAD_NUMBER);
		end else begin
			val_left = opt_len;
			ph_now = (val_left != 16'd0) ? P_VALUE : P_OPT_HEAD;
		end
	endfunction

	function automatic void delta_done();
		if (l_nib >= coapmp_pkg::NIBBLE_EXT1) begin
			ph_now = P_LEN_EXT;
			ext_cnt = (l_nib == coapmp_pkg::NIBBLE_EXT1) ? 2'd1 : 2'd2;
		end else begin
			head_done();
		end
	endfunction

	function automatic coapmp_pkg::result_t classify_byte(input coapmp_pkg::item_t it);
		coapmp_pkg::result_t r;
		logic [2:0] kind;
		logic [7:0] b;
		b = it.data_byte;
		kind = coapmp_pkg::KIND_PAYLOAD;
		case (ph_now)
		P_HEADER: begin
			kind = coapmp_pkg::KIND_HEADER;
			case (hdr_seen)
			2'd0: begin
				hdr_ver = b[7:6];
				hdr_type = b[5:4];
				hdr_tkl = b[3:0];
			end
			2'd1: hdr_code = b;
			2'd2: hdr_id = {b, 8'h00};
			default: hdr_id[7:0] = b;
			endcase
			if (hdr_seen != 2'd3) begin
				hdr_seen = hdr_seen + 2'd1;
			end else if (hdr_ver != cur_ver) begin
				abandon(coapmp_pkg::ST_VERSION);
			end else if (hdr_tkl > cur_max_tok) begin
				abandon(coapmp_pkg::ST_TOKEN);
			end else if (hdr_tkl != 4'd0) begin
				tok_left = hdr_tkl;
				ph_now = P_TOKEN;
			end else begin
				ph_now = P_OPT_HEAD;
			end
		end
		P_TOKEN: begin
			kind = coapmp_pkg::KIND_TOKEN;
			tok_left = tok_left - 4'd1;
			if (tok_left == 4'd0)
				ph_now = P_OPT_HEAD;
		end
		P_OPT_HEAD: begin
			if (b == coapmp_pkg::PAYLOAD_MARKER) begin
				kind = coapmp_pkg::KIND_MARKER;
				ph_now = P_BODY;
			end else begin
				kind = coapmp_pkg::KIND_OPTION;
				if (b[7:4] == coapmp_pkg::NIBBLE_BAD || b[3:0] == coapmp_pkg::NIBBLE_BAD) begin
					abandon(coapmp_pkg::ST_NIBBLE15);
				end else begin
					d_nib = b[7:4];
					l_nib = b[3:0];
					opt_len = (l_nib < coapmp_pkg::NIBBLE_EXT1) ? {12'h000, l_nib} : 16'h0000;
					if (d_nib >= coapmp_pkg::NIBBLE_EXT1) begin
						ph_now = P_DELTA_EXT;
						ext_cnt = (d_nib == coapmp_pkg::NIBBLE_EXT1) ? 2'd1 : 2'd2;
					end else begin
						opt_num = opt_num + {12'h000, d_nib};
						delta_done();
					end
				end
			end
		end
		P_DELTA_EXT: begin
			kind = coapmp_pkg::KIND_OPTION;
			if (ext_cnt == 2'd2) begin
				ext_hi = b;
				ext_cnt = 2'd1;
			end else begin
				opt_num = opt_num + ext_sum(d_nib, b);
				ext_cnt = 2'd0;
				delta_done();
			end
		end
		P_LEN_EXT: begin
			kind = coapmp_pkg::KIND_OPTION;
			if (ext_cnt == 2'd2) begin
				ext_hi = b;
				ext_cnt = 2'd1;
			end else begin
				opt_len = ext_sum(l_nib, b);
				ext_cnt = 2'd0;
				head_done();
			end
		end
		P_VALUE: begin
			kind = coapmp_pkg::KIND_VALUE;
			val_left = val_left - 16'd1;
			if (val_left == 16'd0)
				ph_now = P_OPT_HEAD;
		end
		default: kind = coapmp_pkg::KIND_PAYLOAD;
		endcase

		if (it.end_of_message && err_now == coapmp_pkg::ST_OK) begin
			if (ph_now == P_HEADER)
				err_now = coapmp_pkg::ST_SHORT;
			else if (ph_now == P_TOKEN || ph_now == P_DELTA_EXT || ph_now == P_LEN_EXT ||
					ph_now == P_VALUE)
				err_now = coapmp_pkg::ST_TRUNCATED;
			else if (ph_now == P_BODY && kind == coapmp_pkg::KIND_MARKER)
				err_now = coapmp_pkg::ST_EMPTY_PAYLOAD;
		end

		r = '{byte_kind: kind, echo_byte: b, option_number: opt_num, option_length: opt_len,
			msg_type: hdr_type, token_length: hdr_tkl, code: hdr_code, message_id: hdr_id,
			message_done: it.end_of_message, status: err_now};

		// start over for the next datagram, registers stay
		if (it.end_of_message) begin
			ph_now = P_HEADER;
			hdr_seen = '0;
			tok_left = '0;
			ext_cnt = '0;
			ext_hi = '0;
			d_nib = '0;
			l_nib = '0;
			opt_num = '0;
			opt_len = '0;
			val_left = '0;
			err_now = coapmp_pkg::ST_OK;
			hdr_ver = '0;
			hdr_type = '0;
			hdr_tkl = '0;
			hdr_code = '0;
			hdr_id = '0;
		end
		return r;
	endfunction

	function automatic logic [3:0] nibble_of(input int unsigned v);
		return (v < 13) ? 4'(v) : (v < 269) ? coapmp_pkg::NIBBLE_EXT1 : coapmp_pkg::NIBBLE_EXT2;
	endfunction

	function automatic void put_ext(input int unsigned v);
		if (v >= 269) begin
			frame.push_back(8'((v - 269) >> 8));
			frame.push_back(8'(v - 269));
		end else if (v >= 13) begin
			frame.push_back(8'(v - 13));
		end
	endfunction

	// Mostly well-formed messages with random content; some noise, bad options,
	// stray nibble-15 heads, empty payloads and truncated datagrams.
	function automatic void compose_frame();
		int unsigned roll;
		int unsigned n_opts;
		int unsigned cur;
		int unsigned tgt;
		int unsigned d;
		int unsigned len;
		int unsigned keep;
		logic [1:0] ver;
		logic [3:0] tkl;
		int unsigned cand [$];
		frame.delete();
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 10)) frame.push_back(8'($urandom));
			return;
		end
		ver = ($urandom_range(0, 15) == 0) ? 2'($urandom) : cur_ver;
		tkl = ($urandom_range(0, 15) == 0) ? 4'($urandom) :
			4'($urandom_range(0, 32'(cur_max_tok)));
		frame.push_back({ver, 2'($urandom), tkl});
		repeat (3) frame.push_back(8'($urandom));
		repeat (tkl) frame.push_back(8'($urandom));

		cur = 0;
		n_opts = $urandom_range(0, 4);
		while (n_opts != 0) begin
			n_opts--;
			if ($urandom_range(0, 9) == 0) begin
				tgt = $urandom_range(0, 65535);
			end else begin
				cand.delete();
				foreach (known_opts[j]) begin
					if (known_opts[j] >= cur)
						cand.push_back(known_opts[j]);
				end
				if (cand.size() == 0)
					break;
				tgt = cand[$urandom_range(0, cand.size() - 1)];
			end
			d = (tgt - cur) & 32'hFFFF;
			roll = $urandom_range(0, 39);
			len = (roll == 0) ? $urandom_range(269, 272) :
				(roll < 5) ? $urandom_range(13, 20) : $urandom_range(0, 4);
			frame.push_back({nibble_of(d), nibble_of(len)});
			put_ext(d);
			put_ext(len);
			repeat (len) frame.push_back(8'($urandom));
			cur = tgt;
		end

		roll = $urandom_range(0, 19);
		if (roll == 0) begin
			frame.push_back($urandom_range(0, 1) ? {4'hF, 4'($urandom_range(0, 14))} :
				{4'($urandom_range(0, 14)), 4'hF});
			repeat ($urandom_range(0, 3)) frame.push_back(8'($urandom));
		end else if (roll == 1) begin
			frame.push_back(coapmp_pkg::PAYLOAD_MARKER);
		end else if (roll < 12) begin
			frame.push_back(coapmp_pkg::PAYLOAD_MARKER);
			repeat ($urandom_range(1, 6)) frame.push_back(8'($urandom));
		end

		if ($urandom_range(0, 9) == 0) begin
			keep = $urandom_range(1, frame.size());
			while (frame.size() > keep)
				void'(frame.pop_back());
		end
	endfunction

	// hold the word until it is taken; leave valid high for a back-to-back word
	task automatic send_byte(input logic [7:0] b, input logic eom, input pin_t pin);
		int unsigned gap;
		gap = quiet ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= '{data_byte: b, end_of_message: eom};
		item_pin <= pin;
		do @(posedge clk); while (item_stall);
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		do @(posedge clk); while (reports_due.size() != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_regs(input logic [1:0] ver, input logic [3:0] tok);
		cfg_write <= 1'b1;
		cfg_index <= coapmp_pkg::REG_EXPECTED_VERSION;
		cfg_data <= {2'($urandom), ver};
		@(posedge clk);
		cfg_index <= coapmp_pkg::REG_MAX_TOKEN_LENGTH;
		cfg_data <= tok;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : scoreboard
		due_t due;
		if (arst_n) begin
			if (cfg_write) begin
				if (cfg_index == coapmp_pkg::REG_EXPECTED_VERSION)
					cur_ver = cfg_data[1:0];
				else if (cfg_index == coapmp_pkg::REG_MAX_TOKEN_LENGTH)
					cur_max_tok = cfg_data;
			end
			if (result_valid && !result_stall) begin
				words_out++;
				if (reports_due.size() == 0) begin
					errors++;
					$display("%0t: result word with nothing expected, actual %p", $time, result);
				end else begin
					due = reports_due.pop_front();
					check_field("byte_kind", 32'(due.word.byte_kind), 32'(result.byte_kind));
					check_field("echo_byte", 32'(due.word.echo_byte), 32'(result.echo_byte));
					check_field("option_number", 32'(due.word.option_number),
						32'(result.option_number));
					check_field("option_length", 32'(due.word.option_length),
						32'(result.option_length));
					check_field("msg_type", 32'(due.word.msg_type), 32'(result.msg_type));
					check_field("token_length", 32'(due.word.token_length),
						32'(result.token_length));
					check_field("code", 32'(due.word.code), 32'(result.code));
					check_field("message_id", 32'(due.word.message_id), 32'(result.message_id));
					check_field("message_done", 32'(due.word.message_done),
						32'(result.message_done));
					check_field("status", 32'(due.word.status), 32'(result.status));
					if (due.pin.on && (due.pin.kind != result.byte_kind ||
							due.pin.status != result.status)) begin
						errors++;
						$display("%0t: table row mismatch, expected kind %0d status %0d, %s %0d %s %0d",
							$time, due.pin.kind, due.pin.status, "actual kind",
							result.byte_kind, "status", result.status);
					end
				end
			end
			if (item_valid && !item_stall)
				reports_due.push_back('{word: classify_byte(item), pin: item_pin});
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// receiver: random stall before each word, one long hold-off to back up the input
	initial begin : receiver
		int unsigned n;
		result_stall = 1'b0;
		forever begin
			if (!long_hold_done && words_out >= 200) begin
				long_hold_done = 1'b1;
				result_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end
			n = quiet ? 0 : $urandom_range(0, 10);
			if (n != 0) begin
				result_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
		end
	end

	initial begin : stimulus
		int ph;
		int unsigned sent;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		item_pin = NO_PIN;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;

		// datagrams against the reset register values
		dir_rows = '{
			'{8'hC0, 1'b1, '{1'b1, coapmp_pkg::KIND_HEADER, coapmp_pkg::ST_SHORT}},
			'{8'hC0, 1'b0, NO_PIN}, '{8'hFF, 1'b0, NO_PIN}, '{8'hFF, 1'b0, NO_PIN},
			'{8'hFF, 1'b1, '{1'b1, coapmp_pkg::KIND_HEADER, coapmp_pkg::ST_VERSION}},
			'{8'h4F, 1'b0, NO_PIN}, '{8'h00, 1'b0, NO_PIN}, '{8'h00, 1'b0, NO_PIN},
			'{8'h00, 1'b1, '{1'b1, coapmp_pkg::KIND_HEADER, coapmp_pkg::ST_TOKEN}},
			// two-byte delta wraps to 128, two-byte length wraps to 2
			'{8'h40, 1'b0, NO_PIN}, '{8'h45, 1'b0, NO_PIN}, '{8'h00, 1'b0, NO_PIN},
			'{8'h01, 1'b0, NO_PIN}, '{8'hE0, 1'b0, NO_PIN}, '{8'hFF, 1'b0, NO_PIN},
			'{8'h73, 1'b0, NO_PIN}, '{8'h4E, 1'b0, NO_PIN}, '{8'hFE, 1'b0, NO_PIN},
			'{8'hF5, 1'b0, NO_PIN}, '{8'h11, 1'b0, NO_PIN}, '{8'h22, 1'b0, NO_PIN},
			'{8'hFF, 1'b1, '{1'b1, coapmp_pkg::KIND_MARKER, coapmp_pkg::ST_EMPTY_PAYLOAD}},
			'{8'h50, 1'b0, NO_PIN}, '{8'h00, 1'b0, NO_PIN}, '{8'h00, 1'b0, NO_PIN},
			'{8'h00, 1'b0, NO_PIN}, '{8'h3F, 1'b0, NO_PIN},
			'{8'hAA, 1'b1, '{1'b1, coapmp_pkg::KIND_PAYLOAD, coapmp_pkg::ST_NIBBLE15}},
			'{8'h70, 1'b0, NO_PIN}, '{8'hFF, 1'b0, NO_PIN}, '{8'h00, 1'b0, NO_PIN},
			'{8'h00, 1'b0, NO_PIN},
			'{8'h20, 1'b1, '{1'b1, coapmp_pkg::KIND_OPTION, coapmp_pkg::ST_BAD_NUMBER}}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		foreach (dir_rows[i])
			send_byte(dir_rows[i].b, dir_rows[i].eom, dir_rows[i].pin);

		for (ph = 0; ph < 5; ph++) begin
			settle();
			case (ph)
			0: write_regs(2'd0, 4'd0);
			1: write_regs(2'd3, 4'd15);
			2: write_regs(2'd2, 4'd4);
			3: write_regs(2'($urandom), 4'($urandom));
			default: write_regs(coapmp_pkg::EXPECTED_VERSION_RST,
				coapmp_pkg::MAX_TOKEN_LENGTH_RST);
			endcase
			sent = 0;
			while (sent < ITEMS_PER_SETTING) begin
				quiet = ($urandom_range(0, 3) == 0);
				compose_frame();
				foreach (frame[i])
					send_byte(frame[i], i == frame.size() - 1, NO_PIN);
				sent += frame.size();
			end
		end
		quiet = 1'b0;
		settle();

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
